>>> rtl/dtpg_pkg.sv
// dtpg_pkg: shared constants, mode codes, colors and a color packing helper for the test pattern generator
// no dependencies; imported by dtpg_color, display_test_pattern_generator_top and the testbench
`default_nettype none

package dtpg_pkg;

  localparam int X_W       = 10;
  localparam int Y_W       = 9;
  localparam int MODE_W    = 4;
  localparam int COLOR_W   = 16;
  localparam int LEVEL_W   = 8;
  localparam int BAR_IDX_W = 3;
  localparam int NUM_BARS  = 8;

  localparam int DEF_WIDTH  = 800;
  localparam int DEF_HEIGHT = 480;

  // dividend widths of pos*255 in the gradient levels
  localparam int GX_NW = X_W + LEVEL_W;
  localparam int GY_NW = Y_W + LEVEL_W;

  localparam logic [MODE_W-1:0] MODE_RED     = 4'd0;
  localparam logic [MODE_W-1:0] MODE_GREEN   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_BLUE    = 4'd2;
  localparam logic [MODE_W-1:0] MODE_WHITE   = 4'd3;
  localparam logic [MODE_W-1:0] MODE_BLACK   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_BARS    = 4'd5;
  localparam logic [MODE_W-1:0] MODE_GRAD    = 4'd6;
  localparam logic [MODE_W-1:0] MODE_CHECKER = 4'd7;
  localparam logic [MODE_W-1:0] MODE_BORDER  = 4'd8;

  localparam logic [COLOR_W-1:0] C_WHITE   = 16'hFFFF;
  localparam logic [COLOR_W-1:0] C_YELLOW  = 16'hFFE0;
  localparam logic [COLOR_W-1:0] C_CYAN    = 16'h07FF;
  localparam logic [COLOR_W-1:0] C_GREEN   = 16'h07E0;
  localparam logic [COLOR_W-1:0] C_MAGENTA = 16'hF81F;
  localparam logic [COLOR_W-1:0] C_RED     = 16'hF800;
  localparam logic [COLOR_W-1:0] C_BLUE    = 16'h001F;
  localparam logic [COLOR_W-1:0] C_BLACK   = 16'h0000;

  localparam logic [COLOR_W-1:0] BAR_COLORS [NUM_BARS] = '{
    C_WHITE, C_YELLOW, C_CYAN, C_GREEN, C_MAGENTA, C_RED, C_BLUE, C_BLACK
  };

  typedef logic [COLOR_W-1:0] color_t;

  // gray on red and green, blue level on blue, truncated into 5/6/5 bits
  function automatic color_t pack_gray_blue(input logic [LEVEL_W-1:0] gray,
                                            input logic [LEVEL_W-1:0] blue);
    return {gray[7:3], gray[7:2], blue[7:3]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/dtpg_color.sv
// dtpg_color: combinational color of one pixel for the selected test pattern
// depends on dtpg_pkg; gradient levels use exact constant-reciprocal multiplies
`default_nettype none

module dtpg_color #(
  parameter int WIDTH  = dtpg_pkg::DEF_WIDTH,
  parameter int HEIGHT = dtpg_pkg::DEF_HEIGHT
) (
  input  wire logic [dtpg_pkg::MODE_W-1:0]  pattern_mode,
  input  wire logic [dtpg_pkg::X_W-1:0]     pixel_x,
  input  wire logic [dtpg_pkg::Y_W-1:0]     pixel_y,
  output logic      [dtpg_pkg::COLOR_W-1:0] pixel_color
);
  import dtpg_pkg::*;

  // floor(p/d) == (p*m) >> (n+l) with m = ceil(2^(n+l)/d), l = clog2(d), p < 2^n
  localparam int              XL  = $clog2(WIDTH);
  localparam int              XS  = GX_NW + XL;
  localparam longint unsigned XM  = ((64'd1 << XS) + longint'(WIDTH) - 1) / longint'(WIDTH);
  localparam longint unsigned XK  = XM * 255;
  localparam int              XKW = $clog2(XK + 1);
  localparam int              XPW = X_W + XKW;

  localparam int              YL  = $clog2(HEIGHT);
  localparam int              YS  = GY_NW + YL;
  localparam longint unsigned YM  = ((64'd1 << YS) + longint'(HEIGHT) - 1) / longint'(HEIGHT);
  localparam longint unsigned YK  = YM * 255;
  localparam int              YKW = $clog2(YK + 1);
  localparam int              YPW = Y_W + YKW;

  logic [NUM_BARS-2:0]  bar_ge;
  logic [BAR_IDX_W-1:0] bar_idx;
  logic [XPW-1:0]       x_prod;
  logic [XPW-1:0]       x_quo;
  logic [YPW-1:0]       y_prod;
  logic [YPW-1:0]       y_quo;
  logic [LEVEL_W-1:0]   gray;
  logic [LEVEL_W-1:0]   blue;
  logic                 on_border;

  // bar t starts at column ceil(t*WIDTH/8)
  for (genvar t = 1; t < NUM_BARS; t++) begin : g_bar_thr
    localparam int THR = (t * WIDTH + NUM_BARS - 1) / NUM_BARS;
    assign bar_ge[t-1] = (32'(pixel_x) >= 32'(THR));
  end

  always_comb begin
    bar_idx = '0;
    for (int t = 0; t < NUM_BARS - 1; t++) begin
      bar_idx = bar_idx + BAR_IDX_W'(bar_ge[t]);
    end
  end

  assign x_prod = XPW'(pixel_x) * XPW'(XK);
  assign x_quo  = x_prod >> XS;
  assign gray   = (x_quo > XPW'(255)) ? 8'hFF : x_quo[LEVEL_W-1:0];

  assign y_prod = YPW'(pixel_y) * YPW'(YK);
  assign y_quo  = y_prod >> YS;
  assign blue   = (y_quo > YPW'(255)) ? 8'hFF : y_quo[LEVEL_W-1:0];

  assign on_border = (pixel_x == '0) || (32'(pixel_x) == 32'(WIDTH - 1)) ||
                     (pixel_y == '0) || (32'(pixel_y) == 32'(HEIGHT - 1));

  always_comb begin
    unique case (pattern_mode)
      MODE_RED:     pixel_color = C_RED;
      MODE_GREEN:   pixel_color = C_GREEN;
      MODE_BLUE:    pixel_color = C_BLUE;
      MODE_WHITE:   pixel_color = C_WHITE;
      MODE_BLACK:   pixel_color = C_BLACK;
      MODE_BARS:    pixel_color = BAR_COLORS[bar_idx];
      MODE_GRAD:    pixel_color = pack_gray_blue(gray, blue);
      MODE_CHECKER: pixel_color = (pixel_x[4] ^ pixel_y[4]) ? C_WHITE : C_BLACK;
      MODE_BORDER:  pixel_color = on_border ? C_WHITE : C_BLACK;
      default:      pixel_color = C_BLACK;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/display_test_pattern_generator_top.sv
// display_test_pattern_generator_top: pixel coordinate in, RGB565 test pattern color out
// pixels pass an input register, then a result register; one pixel per cycle sustained while out_stall is low
// input stage moves on when empty or when the result stage takes its value, so a held
// result stalls the input only once both stages are full
// rst_n is synchronous active low: clears both valid flags and sets pattern_mode to 0
// depends on dtpg_pkg and dtpg_color
`default_nettype none

module display_test_pattern_generator_top #(
  parameter int WIDTH  = dtpg_pkg::DEF_WIDTH,
  parameter int HEIGHT = dtpg_pkg::DEF_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [dtpg_pkg::MODE_W-1:0]    cfg_pattern_mode,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [dtpg_pkg::X_W-1:0]       in_pixel_x,
  input  wire logic [dtpg_pkg::Y_W-1:0]       in_pixel_y,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [dtpg_pkg::COLOR_W-1:0]   out_pixel_color
);
  import dtpg_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic              s1_valid_r;
  logic [X_W-1:0]    x_r;
  logic [Y_W-1:0]    y_r;
  logic              out_valid_r;
  color_t            color_r;
  color_t            color_nxt;
  logic              out_en;
  logic              s1_en;

  // result stage takes a new value when empty or its value transfers out
  assign out_en   = !out_valid_r || !out_stall;
  assign s1_en    = !s1_valid_r || out_en;
  assign in_stall = !s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RED;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_pattern_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      x_r <= in_pixel_x;
      y_r <= in_pixel_y;
    end
  end

  dtpg_color #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_color (
    .pattern_mode (mode_r),
    .pixel_x      (x_r),
    .pixel_y      (y_r),
    .pixel_color  (color_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      color_r <= color_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = color_r;

endmodule

`default_nettype wire

>>> tb/tb_display_test_pattern_generator_top.sv
// testbench for display_test_pattern_generator_top: directed pixels, then random pixels per mode
// colors checked against directed expected values or an in-bench pattern predictor; depends on dtpg_pkg and the rtl top
`timescale 1ns / 1ps

module tb_display_test_pattern_generator_top;
  import dtpg_pkg::*;

  localparam int PANEL_W          = DEF_WIDTH;
  localparam int PANEL_H          = DEF_HEIGHT;
  localparam int N_DIRECTED       = 24;
  localparam int RAND_PHASES      = 20;
  localparam int PIXELS_PER_PHASE = 72;
  localparam int CALM_TAIL        = 120;
  localparam int DRAIN_LIMIT      = 2000;

  // mode codes with no pattern behind them
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd9;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic              known;
    color_t            color;
  } pixel_case_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    color_t            color;
  } pixel_exp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [MODE_W-1:0] cfg_pattern_mode = MODE_RED;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [X_W-1:0]    in_pixel_x = '0;
  logic [Y_W-1:0]    in_pixel_y = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  color_t            out_pixel_color;

  pixel_exp_t        color_q [$];
  logic [MODE_W-1:0] cur_mode = MODE_RED;
  logic [15:0]       modes_seen = '0;
  logic              calm = 1'b0;
  int                stall_left = 0;
  int                errors = 0;
  int                pixels_sent = 0;
  int                pixels_checked = 0;

  pixel_case_t directed_rows [N_DIRECTED] = '{
    '{MODE_RED,       10'd0,    9'd0,   1'b1, C_RED},
    '{MODE_GREEN,     10'd799,  9'd479, 1'b1, C_GREEN},
    '{MODE_BLUE,      10'd0,    9'd0,   1'b1, C_BLUE},
    '{MODE_WHITE,     10'd1023, 9'd511, 1'b1, C_WHITE},
    '{MODE_BLACK,     10'd1023, 9'd511, 1'b1, C_BLACK},
    '{MODE_BARS,      10'd0,    9'd0,   1'b1, C_WHITE},
    '{MODE_BARS,      10'd100,  9'd0,   1'b1, C_YELLOW},
    '{MODE_BARS,      10'd799,  9'd479, 1'b1, C_BLACK},
    '{MODE_BARS,      10'd1023, 9'd0,   1'b1, C_BLACK},
    '{MODE_BARS,      10'd450,  9'd200, 1'b0, C_BLACK},
    '{MODE_GRAD,      10'd0,    9'd0,   1'b1, C_BLACK},
    '{MODE_GRAD,      10'd1023, 9'd511, 1'b1, C_WHITE},
    '{MODE_GRAD,      10'd400,  9'd240, 1'b0, C_BLACK},
    '{MODE_CHECKER,   10'd0,    9'd0,   1'b1, C_BLACK},
    '{MODE_CHECKER,   10'd16,   9'd0,   1'b1, C_WHITE},
    '{MODE_CHECKER,   10'd16,   9'd16,  1'b1, C_BLACK},
    '{MODE_BORDER,    10'd0,    9'd200, 1'b1, C_WHITE},
    '{MODE_BORDER,    10'd799,  9'd200, 1'b1, C_WHITE},
    '{MODE_BORDER,    10'd300,  9'd0,   1'b1, C_WHITE},
    '{MODE_BORDER,    10'd300,  9'd479, 1'b1, C_WHITE},
    '{MODE_BORDER,    10'd300,  9'd200, 1'b1, C_BLACK},
    '{MODE_BORDER,    10'd1023, 9'd511, 1'b1, C_BLACK},
    '{MODE_UNUSED_LO, 10'd5,    9'd5,   1'b1, C_BLACK},
    '{MODE_UNUSED_HI, 10'd1023, 9'd511, 1'b1, C_BLACK}
  };

  display_test_pattern_generator_top #(
    .WIDTH (PANEL_W),
    .HEIGHT(PANEL_H)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_pattern_mode(cfg_pattern_mode),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_color (out_pixel_color)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic color_t predict_color(input logic [MODE_W-1:0] mode,
                                           input logic [X_W-1:0] x,
                                           input logic [Y_W-1:0] y);
    int unsigned bar;
    int unsigned gray;
    int unsigned blue;
    case (mode)
      MODE_RED:   return C_RED;
      MODE_GREEN: return C_GREEN;
      MODE_BLUE:  return C_BLUE;
      MODE_WHITE: return C_WHITE;
      MODE_BLACK: return C_BLACK;
      MODE_BARS: begin
        bar = (int'(x) * NUM_BARS) / PANEL_W;
        if (bar > NUM_BARS - 1) bar = NUM_BARS - 1;
        return BAR_COLORS[bar];
      end
      MODE_GRAD: begin
        gray = (int'(x) * 255) / PANEL_W;
        blue = (int'(y) * 255) / PANEL_H;
        if (gray > 255) gray = 255;
        if (blue > 255) blue = 255;
        return color_t'(((gray & 'hF8) << 8) | ((gray & 'hFC) << 3) | (blue >> 3));
      end
      // 16-pixel squares: bit 4 of each coordinate picks the square parity
      MODE_CHECKER: return (x[4] ^ y[4]) ? C_WHITE : C_BLACK;
      MODE_BORDER: begin
        if (x == 0 || x == PANEL_W - 1 || y == 0 || y == PANEL_H - 1) return C_WHITE;
        return C_BLACK;
      end
      default: return C_BLACK;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic send_pixel(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                            input logic known, input color_t color);
    pixel_exp_t e;
    e.mode  = cur_mode;
    e.x     = x;
    e.y     = y;
    e.color = known ? color : predict_color(cur_mode, x, y);
    in_valid   <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    color_q.push_back(e);
    modes_seen[cur_mode] = 1'b1;
    pixels_sent++;
  endtask

  // mode changes only once every pixel in flight has come out
  task automatic set_mode(input logic [MODE_W-1:0] mode);
    in_valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    cfg_wr_en        <= 1'b1;
    cfg_pattern_mode <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode = mode;
  endtask

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : color_check
    pixel_exp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (color_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel color 0x%04h", out_pixel_color));
      end else begin
        want = color_q.pop_front();
        pixels_checked++;
        if (out_pixel_color !== want.color)
          report_mismatch($sformatf("mode %0d x %0d y %0d: color 0x%04h, want 0x%04h",
                                    want.mode, want.x, want.y, out_pixel_color,
                                    want.color));
      end
    end
  end

  initial begin : stimulus
    logic [MODE_W-1:0] mode;
    int                sel;
    int                xi;
    int                yi;
    int                idx;
    int                waited;
    logic              calm_phase;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, starting on the reset mode
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].mode != cur_mode) set_mode(directed_rows[i].mode);
      send_pixel(directed_rows[i].x, directed_rows[i].y, directed_rows[i].known,
                 directed_rows[i].color);
    end

    // random phases: every mode code once, then extra rounds on the patterned modes
    idx = 0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      mode = (p < 16) ? p[MODE_W-1:0]
                      : MODE_W'($urandom_range(int'(MODE_BARS), int'(MODE_BORDER)));
      set_mode(mode);
      calm_phase = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < PIXELS_PER_PHASE; k++) begin
        calm = calm_phase || (idx >= RAND_PHASES * PIXELS_PER_PHASE - CALM_TAIL);
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
          xi = $urandom_range(0, PANEL_W - 1);
          yi = $urandom_range(0, PANEL_H - 1);
        end else if (sel < 8) begin
          // around bar boundaries and panel edges; -1 wraps to the top code
          xi = (PANEL_W / NUM_BARS) * $urandom_range(0, NUM_BARS) + $urandom_range(0, 2) - 1;
          yi = $urandom_range(0, 1) ? $urandom_range(0, 2) - 1
                                    : PANEL_H - 2 + $urandom_range(0, 2);
        end else begin
          xi = $urandom_range(0, (1 << X_W) - 1);
          yi = $urandom_range(0, (1 << Y_W) - 1);
        end
        if (!calm && $urandom_range(0, 3) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        send_pixel(X_W'(xi), Y_W'(yi), 1'b0, C_BLACK);
        idx++;
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (color_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (color_q.size() != 0)
      report_mismatch($sformatf("%0d pixel colors never came out", color_q.size()));
    repeat (8) @(posedge clk);

    $display("%0d pixels sent, %0d colors checked, mode codes used 0x%04h",
             pixels_sent, pixels_checked, modes_seen);
    $display("covered solid, bar, gradient, checker, border and unused modes, %0d errors",
             errors);
    if (errors == 0) begin
      $display("display_test_pattern_generator_top test passed");
    end else begin
      $display("display_test_pattern_generator_top test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d pixel colors outstanding", color_q.size());
    $display("display_test_pattern_generator_top test failed");
    $finish;
  end

endmodule
